// ===== rtl/rle_pb_pkg.sv =====
`timescale 1ns / 1ps
package rle_pb_pkg;

   localparam int unsigned MaxPacket = 127;
   localparam int unsigned LookDepth = MaxPacket + 1;
   localparam int unsigned PtrW      = $clog2(LookDepth);
   localparam int unsigned FillW     = $clog2(LookDepth + 1);
   localparam int unsigned LenW      = $clog2(MaxPacket + 1);
   localparam int unsigned RawW      = 17;
   localparam int unsigned CodedW    = 18;
   localparam int unsigned RspW      = 104;

   localparam logic [LenW-1:0] MinRunFloor = LenW'(3);
   localparam logic [LenW-1:0] MinRunReset = LenW'(3);
   localparam logic [RawW-1:0] RawSat      = RawW'(65536);
   localparam logic [CodedW-1:0] CodedSat  = CodedW'(131072);

   typedef struct packed {
      logic accept;
      logic take;
      logic hdr_send;
      logic body_send;
      logic frame_clear;
   } cmd_type;

   typedef struct packed {
      logic pkt_ready;
      logic frame_end;
      logic body_last;
      logic byte_ready;
   } stat_type;

endpackage

// ===== rtl/rle_pb_packer.sv =====
`timescale 1ns / 1ps
module rle_pb_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic [7:0]                   byte_data,
   input  logic                         byte_final,
   output logic                         byte_ready,
   input  logic                         raw_inc,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // byte_count, byte0..byte7, compressed_size, original_size, zero pad
   output logic [rle_pb_pkg::RspW-1:0]  rsp_tdata,
   output logic                         rsp_tlast
);

   logic [63:0]                     word_ff, word_in;
   logic [2:0]                      fill_ff, fill_in;
   logic [rle_pb_pkg::RawW-1:0]     raw_ff, raw_in;
   logic [rle_pb_pkg::CodedW-1:0]   coded_ff, coded_in, coded_next;
   logic                            out_v_ff, out_v_in;
   logic [3:0]                      cnt_ff;
   logic [63:0]                     bytes_ff;
   logic                            last_ff;
   logic [rle_pb_pkg::CodedW-1:0]   csize_ff;
   logic [rle_pb_pkg::RawW-1:0]     osize_ff;
   logic                            completing, fire;
   logic [63:0]                     merged;

   assign completing = (fill_ff == 3'd7) || byte_final;
   assign byte_ready = !completing || !out_v_ff || rsp_tready;
   assign fire       = byte_valid && byte_ready;
   assign merged     = word_ff | ({56'd0, byte_data} << {fill_ff, 3'b000});
   assign coded_next = (coded_ff < rle_pb_pkg::CodedSat) ? coded_ff + 1'b1 : coded_ff;

   always_comb begin
      word_in  = word_ff;
      fill_in  = fill_ff;
      coded_in = coded_ff;
      raw_in   = raw_ff;
      out_v_in = out_v_ff && !rsp_tready;
      if (raw_inc && raw_ff < rle_pb_pkg::RawSat) begin
         raw_in = raw_ff + 1'b1;
      end
      if (fire) begin
         coded_in = coded_next;
         if (completing) begin
            word_in  = 64'd0;
            fill_in  = 3'd0;
            out_v_in = 1'b1;
            if (byte_final) begin
               coded_in = '0;
               raw_in   = '0;
            end
         end else begin
            word_in = merged;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= 64'd0;
         fill_ff  <= 3'd0;
         raw_ff   <= '0;
         coded_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         fill_ff  <= fill_in;
         raw_ff   <= raw_in;
         coded_ff <= coded_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && completing) begin
         cnt_ff   <= {1'b0, fill_ff} + 4'd1;
         bytes_ff <= merged;
         last_ff  <= byte_final;
         csize_ff <= byte_final ? coded_next : '0;
         osize_ff <= byte_final ? raw_ff : '0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, osize_ff, csize_ff, bytes_ff, cnt_ff};

   property p_full_word_unless_final;
      @(posedge clock) disable iff (reset)
         (fire && completing && !byte_final) |=> (cnt_ff == 4'd8);
   endproperty
   a_full_word_unless_final: assert property (p_full_word_unless_final)
      else $error("non-final word left with fewer than eight bytes");

   property p_hold_when_stalled;
      @(posedge clock) disable iff (reset)
         (out_v_ff && !rsp_tready) |=> out_v_ff;
   endproperty
   a_hold_when_stalled: assert property (p_hold_when_stalled)
      else $error("pending word dropped while stalled");

   property p_counts_clear_after_final;
      @(posedge clock) disable iff (reset)
         (fire && byte_final) |=> (coded_ff == '0 && fill_ff == 3'd0);
   endproperty
   a_counts_clear_after_final: assert property (p_counts_clear_after_final)
      else $error("frame state not cleared after final word");

endmodule

// ===== rtl/rle_pb_dpath.sv =====
`timescale 1ns / 1ps
module rle_pb_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  rle_pb_pkg::cmd_type          cmd,
   output rle_pb_pkg::stat_type         stat,
   input  logic [7:0]                   in_byte,
   input  logic                         in_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [6:0]                   csr_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rle_pb_pkg::RspW-1:0]  rsp_tdata,
   output logic                         rsp_tlast
);

   localparam logic [1:0] MODE_RUN   = 2'd0;
   localparam logic [1:0] MODE_BREAK = 2'd1;
   localparam logic [1:0] MODE_LIT   = 2'd2;

   localparam logic [rle_pb_pkg::FillW-1:0] FillFull =
      rle_pb_pkg::FillW'(rle_pb_pkg::LookDepth);
   localparam logic [rle_pb_pkg::FillW-1:0] FillMaxRun =
      rle_pb_pkg::FillW'(rle_pb_pkg::MaxPacket);
   localparam logic [rle_pb_pkg::LenW-1:0] LenMax =
      rle_pb_pkg::LenW'(rle_pb_pkg::MaxPacket);

   function automatic logic [rle_pb_pkg::LenW-1:0] LenW1();
      return rle_pb_pkg::LenW'(1);
   endfunction

   logic [7:0]                       mem [0:rle_pb_pkg::LookDepth-1];
   logic [7:0]                       mem_q_ff;
   logic [rle_pb_pkg::LenW-1:0]      min_run_ff;
   logic [rle_pb_pkg::FillW-1:0]     fill_ff;
   logic [rle_pb_pkg::PtrW-1:0]      head_ff, rd_ff, rd_in, tail;
   logic [1:0]                       mode_ff;
   logic [rle_pb_pkg::LenW-1:0]      streak_ff;
   logic                             ended_ff;
   logic [7:0]                       prev_ff;
   logic [7:0]                       hdr_ff;
   logic [rle_pb_pkg::LenW-1:0]      remain_ff;
   logic                             final_ff;
   logic [rle_pb_pkg::LenW-1:0]      m;
   logic                             f_ge_m;
   logic                             pkt, rep;
   logic [rle_pb_pkg::LenW-1:0]      len;
   logic [rle_pb_pkg::FillW-1:0]     fill_left;
   logic                             body_fire;
   logic                             byte_ready;

   assign m      = (min_run_ff < rle_pb_pkg::MinRunFloor) ? rle_pb_pkg::MinRunFloor
                                                          : min_run_ff;
   assign f_ge_m = fill_ff >= {1'b0, m};
   assign tail   = head_ff + fill_ff[rle_pb_pkg::PtrW-1:0];

   // Packet decision for the head of the pending bytes.
   always_comb begin
      pkt = 1'b0;
      rep = 1'b0;
      len = '0;
      case (mode_ff)
         MODE_RUN: begin
            if (fill_ff != '0) begin
               if (f_ge_m && (fill_ff == FillMaxRun || ended_ff)) begin
                  pkt = 1'b1;
                  rep = 1'b1;
                  len = fill_ff[rle_pb_pkg::LenW-1:0];
               end else if (ended_ff) begin
                  pkt = 1'b1;
                  len = fill_ff[rle_pb_pkg::LenW-1:0];
               end
            end
         end
         MODE_BREAK: begin
            pkt = 1'b1;
            rep = 1'b1;
            len = rle_pb_pkg::LenW'(fill_ff - 1'b1);
         end
         MODE_LIT: begin
            if (streak_ff == m) begin
               pkt = 1'b1;
               len = rle_pb_pkg::LenW'(fill_ff - {1'b0, m});
            end else if (fill_ff == FillFull) begin
               pkt = 1'b1;
               len = LenMax;
            end else if (ended_ff) begin
               pkt = 1'b1;
               len = fill_ff[rle_pb_pkg::LenW-1:0];
            end
         end
         default: begin
            pkt = 1'b0;
         end
      endcase
   end

   assign fill_left = fill_ff - {1'b0, len};
   assign body_fire = cmd.body_send && byte_ready;
   assign rd_in     = cmd.take ? head_ff : (body_fire ? rd_ff + 1'b1 : rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[tail] <= in_byte;
      end
      mem_q_ff <= mem[rd_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= rle_pb_pkg::MinRunReset;
         fill_ff    <= '0;
         head_ff    <= '0;
         rd_ff      <= '0;
         mode_ff    <= MODE_RUN;
         streak_ff  <= '0;
         ended_ff   <= 1'b0;
         remain_ff  <= '0;
         final_ff   <= 1'b0;
      end else begin
         rd_ff <= rd_in;
         if (csr_valid) begin
            min_run_ff <= csr_data;
         end
         if (cmd.accept) begin
            fill_ff  <= fill_ff + 1'b1;
            ended_ff <= in_last;
            if (mode_ff == MODE_LIT) begin
               streak_ff <= (in_byte == prev_ff) ? streak_ff + 1'b1 : LenW1();
            end else if (fill_ff != '0 && in_byte != prev_ff) begin
               // A run at the head is broken by a different byte.
               mode_ff   <= f_ge_m ? MODE_BREAK : MODE_LIT;
               streak_ff <= LenW1();
            end
         end
         if (cmd.take) begin
            // What remains after any packet is a plain run at the head.
            head_ff   <= head_ff + len;
            fill_ff   <= fill_left;
            mode_ff   <= MODE_RUN;
            remain_ff <= rep ? LenW1() : len;
            final_ff  <= ended_ff && (fill_left == '0);
         end else if (body_fire) begin
            remain_ff <= remain_ff - 1'b1;
         end
         if (cmd.frame_clear) begin
            ended_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prev_ff <= in_byte;
      end
      if (cmd.take) begin
         hdr_ff <= {rep, len};
      end
   end

   rle_pb_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (cmd.hdr_send || cmd.body_send),
      .byte_data  (cmd.hdr_send ? hdr_ff : mem_q_ff),
      .byte_final (cmd.body_send && remain_ff == LenW1() && final_ff),
      .byte_ready (byte_ready),
      .raw_inc    (cmd.accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign csr_ready       = 1'b1;
   assign stat.pkt_ready  = pkt;
   assign stat.frame_end  = ended_ff && (fill_ff == '0);
   assign stat.body_last  = remain_ff == LenW1();
   assign stat.byte_ready = byte_ready;

   property p_fill_bound;
      @(posedge clock) disable iff (reset) fill_ff <= FillFull;
   endproperty
   a_fill_bound: assert property (p_fill_bound)
      else $error("lookahead fill beyond its depth");

   property p_take_nonempty;
      @(posedge clock) disable iff (reset) cmd.take |-> (fill_ff != '0 && len != '0);
   endproperty
   a_take_nonempty: assert property (p_take_nonempty)
      else $error("packet taken from an empty lookahead");

   property p_break_has_run;
      @(posedge clock) disable iff (reset)
         (mode_ff == MODE_BREAK) |-> (fill_ff > {1'b0, m});
   endproperty
   a_break_has_run: assert property (p_break_has_run)
      else $error("broken run shorter than the repeat threshold");

endmodule

// ===== rtl/rle_pb_ctrl.sv =====
`timescale 1ns / 1ps
module rle_pb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rle_pb_pkg::stat_type  stat,
   output rle_pb_pkg::cmd_type   cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_HDR    = 2'd2;
   localparam logic [1:0] S_BODY   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_tready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.pkt_ready) begin
               cmd.take = 1'b1;
               state_in = S_HDR;
            end else begin
               cmd.frame_clear = stat.frame_end;
               state_in        = S_IDLE;
            end
         end
         S_HDR: begin
            cmd.hdr_send = 1'b1;
            if (stat.byte_ready) begin
               state_in = S_BODY;
            end
         end
         S_BODY: begin
            cmd.body_send = 1'b1;
            if (stat.byte_ready && stat.body_last) begin
               state_in = S_DECIDE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   property p_take_then_header;
      @(posedge clock) disable iff (reset) cmd.take |=> (state_ff == S_HDR);
   endproperty
   a_take_then_header: assert property (p_take_then_header)
      else $error("packet taken without header phase");

   property p_accept_then_decide;
      @(posedge clock) disable iff (reset) cmd.accept |=> (state_ff == S_DECIDE);
   endproperty
   a_accept_then_decide: assert property (p_accept_then_decide)
      else $error("accepted byte not followed by a decision");

   property p_one_command;
      @(posedge clock) disable iff (reset)
         $onehot0({cmd.accept, cmd.take, cmd.hdr_send, cmd.body_send});
   endproperty
   a_one_command: assert property (p_one_command)
      else $error("conflicting datapath commands");

endmodule

// ===== rtl/rle_packbits_encoder_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// req       in         req_tvalid/req_tready    tdata: data_byte; tlast: last_in
// rsp       out        rsp_tvalid/rsp_tready    tdata: word + sizes; tlast: last_out
// csr       in         csr_valid/csr_ready      csr_data: min_run
//
// Each raw byte is accepted into the 128-entry lookahead memory and then goes
// to the packet decision. A packet it completes is sent as a header byte and then
// its body bytes, read one per cycle from the memory port unless the packer stalls.
// Reset is synchronous; the lookahead memory needs no clearing.
// A stalled result channel holds the packer, and with it the controller.
module rle_packbits_encoder_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [7:0] data_byte
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [3:0] byte_count, [67:4] byte0..byte7, [85:68] compressed_size,
   // [102:86] original_size, [103] zero
   output logic [rle_pb_pkg::RspW-1:0]  rsp_tdata,
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [6:0]                   csr_data
);

   rle_pb_pkg::cmd_type  cmd;
   rle_pb_pkg::stat_type stat;

   rle_pb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rle_pb_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
